// ===== design/lpbg_pkg.sv =====
package lpbg_pkg;

  // Field widths.
  localparam int PtW      = 18;
  localparam int PixW     = 20;
  localparam int ClsW     = 4;
  localparam int BoxW     = 12;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 12;
  localparam int InDataW  = 56;
  localparam int OutDataW = 104;
  localparam int OutUsedW = 3 * PtW + 2 * PixW + ClsW;

  // Datapath widths. The homogeneous sums stay below 2**43 in magnitude,
  // so the scaled numerator fits 48 bits and the depth below 2**34.
  localparam int CoefW     = 28;
  localparam int ProdW     = CoefW + PtW;
  localparam int HW        = 46;
  localparam int MagW      = 44;
  localparam int DvdW      = 48;
  localparam int DivW      = 34;
  localparam int QW        = 50;
  localparam int NumTerms  = 12;
  localparam int DivCycles = DvdW / 2;
  localparam int CntW      = 5;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegBoxLeft   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegBoxTop    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegBoxWidth  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegBoxHeight = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSignClass = 3'd4;
  localparam logic [CfgIdxW-1:0] RegBoxValid  = 3'd5;

  localparam logic [ClsW-1:0] ClassUnknown = 4'hF;

  // Homogeneous coordinate: 1.0 in Q10.
  localparam logic signed [PtW-1:0] HomOne = 18'sd1024;

  // Pixel offsets in 1/16 pixel and the output saturation limits.
  localparam logic signed [QW-1:0] OfsU   = 50'sd480;
  localparam logic signed [QW-1:0] OfsV   = 50'sd160;
  localparam logic signed [QW-1:0] PixMax = 50'sd524287;
  localparam logic signed [QW-1:0] PixMin = -50'sd524288;

  // Intrinsics in Q16 and extrinsics in units of 1/10000.
  localparam longint CamK [3][3] = '{
    '{39323013, 0, 21525105},
    '{0, 39371133, 15478793},
    '{0, 0, 65536}
  };
  localparam longint CamE [3][4] = '{
    '{572, -9980, 270, 271},
    '{1006, -211, -9947, -2647},
    '{9933, 596, 992, -1308}
  };

  // One entry of the projection matrix in Q16, rounded half away from zero.
  function automatic longint proj_entry(int r, int c);
    longint s;
    s = 0;
    for (int k = 0; k < 3; k++) begin
      s += CamK[r][k] * CamE[k][c];
    end
    if (s >= 0) begin
      return (s + 5000) / 10000;
    end
    return -((-s + 5000) / 10000);
  endfunction

  // Projection matrix, row by row, four columns per row.
  localparam logic signed [CoefW-1:0] ProjCoef [NumTerms] = '{
    CoefW'(proj_entry(0, 0)), CoefW'(proj_entry(0, 1)),
    CoefW'(proj_entry(0, 2)), CoefW'(proj_entry(0, 3)),
    CoefW'(proj_entry(1, 0)), CoefW'(proj_entry(1, 1)),
    CoefW'(proj_entry(1, 2)), CoefW'(proj_entry(1, 3)),
    CoefW'(proj_entry(2, 0)), CoefW'(proj_entry(2, 1)),
    CoefW'(proj_entry(2, 2)), CoefW'(proj_entry(2, 3))
  };

endpackage

// ===== design/lidar_point_bbox_projection_gate.sv =====
// Lidar point to camera box gate.
//
// Input stream (s_axis_*): one lidar point per request, x, y and z in Q10 meters;
// tlast marks the final point of a frame. Output stream (m_axis_*): at most one
// request per frame, carrying the first point whose projection lies inside the
// configured box, its pixel position in 1/16 pixel and the configured class.
// Configuration (cfg_*): register index and data, always ready; the user must see
// that they are written while the block is idle, as the block does not enforce it.
//
// Each point is projected with one shared 28x18 multiplier (twelve products,
// one per cycle) and then divided by depth twice with one shared radix-4
// restoring divider. The block takes no new point until the current one is
// finished, whether it is projected or skipped (no box set, or the frame
// already has a hit); a skipped point goes straight to the final state.
// The result register parts the two sides: a waiting result does not block the
// next point; only a second hit stalls in its final cycle until the first
// result is taken. Reset clears the registers to their defaults, the found
// flag and the output valid.
module lidar_point_bbox_projection_gate
  import lpbg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input stream. tdata: point_x, point_y, point_z, zero fill.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [InDataW-1:0]    s_axis_tdata,
  input  logic                  s_axis_tlast,
  // Output stream. tdata: hit_x, hit_y, hit_z, pixel_u, pixel_v, class_out,
  // zero fill.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OutDataW-1:0]   m_axis_tdata,
  // Configuration write channel.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxW-1:0]    cfg_index_i,
  input  logic [CfgDataW-1:0]   cfg_wdata_i
);

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StSetup,
    StLoad,
    StDiv,
    StFix,
    StChk,
    StDone
  } state_e;

  state_e                state_q;
  logic [CntW-1:0]       cnt_q;
  logic                  axis_q;
  logic                  found_q;
  logic                  m_valid_q;

  logic [BoxW-1:0]       box_left_q, box_top_q, box_width_q, box_height_q;
  logic [ClsW-1:0]       sign_class_q;
  logic                  box_valid_q;

  // Datapath registers.
  logic signed [PtW-1:0]   x_q, y_q, z_q;
  logic                    last_q;
  logic signed [ProdW-1:0] prod_q;
  logic [1:0]              prod_row_q;
  logic signed [HW-1:0]    h_q [3];
  logic [DivW-1:0]         d_q;
  logic                    h2_neg_q;
  logic                    n_neg_q;
  logic [DvdW-1:0]         dvd_q;
  logic [DivW-1:0]         rem_q;
  logic signed [QW-1:0]    q_q;
  logic                    r_zero_q;
  logic                    in_u_q;
  logic                    hit_q;
  logic [PixW-1:0]         pix_u_q, pix_v_q;
  logic [OutUsedW-1:0]     out_q;

  logic in_acc;
  logic done_go;

  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign done_go       = (state_q == StDone) && (!hit_q || !m_valid_q || m_axis_tready);

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OutDataW - OutUsedW){1'b0}}, out_q};

  // Multiplier operands: coefficient from the table, point column by counter.
  logic signed [CoefW-1:0] coef_sel;
  logic signed [PtW-1:0]   opnd_sel;
  logic signed [ProdW-1:0] prod_d;

  always_comb begin
    coef_sel = (cnt_q < CntW'(NumTerms)) ? ProjCoef[cnt_q[3:0]] : '0;
    unique case (cnt_q[1:0])
      2'd0:    opnd_sel = x_q;
      2'd1:    opnd_sel = y_q;
      2'd2:    opnd_sel = z_q;
      default: opnd_sel = HomOne;
    endcase
    prod_d = coef_sel * opnd_sel;
  end

  // Numerator for the current axis, sign folded with the sign of the depth.
  logic signed [HW-1:0] num_sel;
  logic signed [HW-1:0] num_mag;
  logic signed [HW-1:0] h2_abs;

  always_comb begin
    num_sel = axis_q ? h_q[1] : h_q[0];
    num_mag = num_sel[HW-1] ? -num_sel : num_sel;
    h2_abs  = h_q[2][HW-1] ? -h_q[2] : h_q[2];
  end

  // Two restoring division steps per cycle.
  logic [DivW:0]   rem_a, rem_b;
  logic [DivW-1:0] rem_1, rem_2;
  logic            qb_1, qb_2;

  always_comb begin
    rem_a = {rem_q, dvd_q[DvdW-1]};
    if (rem_a >= {1'b0, d_q}) begin
      rem_1 = DivW'(rem_a - {1'b0, d_q});
      qb_1  = 1'b1;
    end else begin
      rem_1 = rem_a[DivW-1:0];
      qb_1  = 1'b0;
    end
    rem_b = {rem_1, dvd_q[DvdW-2]};
    if (rem_b >= {1'b0, d_q}) begin
      rem_2 = DivW'(rem_b - {1'b0, d_q});
      qb_2  = 1'b1;
    end else begin
      rem_2 = rem_b[DivW-1:0];
      qb_2  = 1'b0;
    end
  end

  // Floor correction of the finished quotient; the pixel offset is taken off when it is registered.
  logic [QW-1:0]        q_mag;
  logic signed [QW-1:0] q_floor;
  logic                 r_zero;

  always_comb begin
    r_zero = (rem_q == '0);
    q_mag  = QW'(dvd_q);
    if (!n_neg_q) begin
      q_floor = signed'(q_mag);
    end else if (r_zero) begin
      q_floor = -signed'(q_mag);
    end else begin
      q_floor = signed'(~q_mag);
    end
  end

  // Box span test and saturation on the corrected quotient.
  logic [BoxW-1:0]       span_lo_px, span_len_px;
  logic signed [QW-1:0]  span_lo, span_hi;
  logic                  in_span;
  logic [PixW-1:0]       pix_sat;

  always_comb begin
    span_lo_px  = axis_q ? box_top_q : box_left_q;
    span_len_px = axis_q ? box_height_q : box_width_q;
    span_lo     = signed'(QW'({span_lo_px, 4'b0000}));
    span_hi     = signed'(QW'({({1'b0, span_lo_px} + {1'b0, span_len_px}), 4'b0000}));
    in_span     = (q_q >= span_lo) && ((q_q < span_hi) || ((q_q == span_hi) && r_zero_q));
    if (q_q > PixMax) begin
      pix_sat = PixMax[PixW-1:0];
    end else if (q_q < PixMin) begin
      pix_sat = PixMin[PixW-1:0];
    end else begin
      pix_sat = q_q[PixW-1:0];
    end
  end

  // Sequencer, configuration registers and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      cnt_q        <= '0;
      axis_q       <= 1'b0;
      found_q      <= 1'b0;
      m_valid_q    <= 1'b0;
      box_left_q   <= '0;
      box_top_q    <= '0;
      box_width_q  <= '0;
      box_height_q <= '0;
      sign_class_q <= ClassUnknown;
      box_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          RegBoxLeft:   box_left_q   <= cfg_wdata_i;
          RegBoxTop:    box_top_q    <= cfg_wdata_i;
          RegBoxWidth:  box_width_q  <= cfg_wdata_i;
          RegBoxHeight: box_height_q <= cfg_wdata_i;
          RegSignClass: sign_class_q <= cfg_wdata_i[ClsW-1:0];
          RegBoxValid:  box_valid_q  <= cfg_wdata_i[0];
          default: ;
        endcase
      end

      // A finished hit sets the output valid; a taken request clears it.
      if (done_go && hit_q) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            cnt_q <= '0;
            if (box_valid_q && !found_q) begin
              state_q <= StMul;
            end else begin
              state_q <= StDone;
            end
          end
        end
        StMul: begin
          if (cnt_q == CntW'(NumTerms)) begin
            cnt_q   <= '0;
            state_q <= StSetup;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        StSetup: begin
          axis_q  <= 1'b0;
          state_q <= (h_q[2] == '0) ? StDone : StLoad;
        end
        StLoad: begin
          cnt_q   <= '0;
          state_q <= StDiv;
        end
        StDiv: begin
          if (cnt_q == CntW'(DivCycles - 1)) begin
            state_q <= StFix;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        StFix: begin
          state_q <= StChk;
        end
        StChk: begin
          if (!axis_q) begin
            axis_q  <= 1'b1;
            state_q <= StLoad;
          end else begin
            state_q <= StDone;
          end
        end
        StDone: begin
          if (done_go) begin
            found_q <= (found_q || hit_q) && !last_q;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q    <= s_axis_tdata[PtW-1:0];
      y_q    <= s_axis_tdata[2*PtW-1:PtW];
      z_q    <= s_axis_tdata[3*PtW-1:2*PtW];
      last_q <= s_axis_tlast;
      hit_q  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        h_q[i] <= '0;
      end
    end

    // Multiply one term per cycle, accumulate it into its row the cycle after.
    if (state_q == StMul) begin
      prod_q     <= prod_d;
      prod_row_q <= cnt_q[3:2];
      if (cnt_q != '0) begin
        h_q[prod_row_q] <= h_q[prod_row_q] + prod_q;
      end
    end

    if (state_q == StSetup) begin
      d_q      <= h2_abs[DivW-1:0];
      h2_neg_q <= h_q[2][HW-1];
    end

    // Scale the numerator by 16 and start a division.
    if (state_q == StLoad) begin
      n_neg_q <= num_sel[HW-1] ^ h2_neg_q;
      dvd_q   <= {num_mag[MagW-1:0], 4'b0000};
      rem_q   <= '0;
    end

    if (state_q == StDiv) begin
      dvd_q <= {dvd_q[DvdW-3:0], qb_1, qb_2};
      rem_q <= rem_2;
    end

    if (state_q == StFix) begin
      q_q      <= q_floor - (axis_q ? OfsV : OfsU);
      r_zero_q <= r_zero;
    end

    if (state_q == StChk) begin
      if (!axis_q) begin
        in_u_q  <= in_span;
        pix_u_q <= pix_sat;
      end else begin
        hit_q   <= in_u_q && in_span;
        pix_v_q <= pix_sat;
      end
    end

    if (done_go && hit_q) begin
      out_q <= {sign_class_q, pix_v_q, pix_u_q, z_q, y_q, x_q};
    end
  end

endmodule

// ===== design/lpbg_checker.sv =====
module lpbg_port_props
  import lpbg_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  // A result that waits for the receiver keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Each accepted point keeps the block busy and closes the input.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after an accepted point");

  // A new result appears only as a point finishes, while the input is closed.
  a_result_from_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a point in work");

  // The fill bits above the class field stay zero.
  a_out_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[OutDataW-1:OutUsedW] == '0))
    else $error("nonzero fill bits in result");

endmodule

bind lidar_point_bbox_projection_gate lpbg_port_props u_lpbg_port_props (.*);

// ===== sim/lpbg_checker.sv =====
// Watches the point stream, the hit stream and the register channel of the
// projection gate, predicts the hit for every accepted point and compares it
// with what the block sends.
module lpbg_checker
  import lpbg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  // Fields from bit 0 up: point_x, point_y, point_z, zero fill.
  input  logic [InDataW-1:0]    in_data_i,
  input  logic                  in_last_i,
  input  logic                  hit_valid_i,
  input  logic                  hit_ready_i,
  // Fields from bit 0 up: hit_x, hit_y, hit_z, pixel_u, pixel_v, class_out,
  // zero fill.
  input  logic [OutDataW-1:0]   hit_data_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CfgIdxW-1:0]    cfg_index_i,
  input  logic [CfgDataW-1:0]   cfg_wdata_i,
  output int                    fail_count_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [PtW-1:0]  px;
    logic signed [PtW-1:0]  py;
    logic signed [PtW-1:0]  pz;
    logic signed [PixW-1:0] pu;
    logic signed [PixW-1:0] pv;
    logic signed [ClsW-1:0] cls;
  } hit_t;

  // Pinhole intrinsics in Q16 and lidar-to-camera extrinsics in 1/10000.
  localparam longint IntrinsicQ16 [3][3] = '{
    '{39323013, 0, 21525105},
    '{0, 39371133, 15478793},
    '{0, 0, 65536}
  };
  localparam longint ExtrinsicE4 [3][4] = '{
    '{572, -9980, 270, 271},
    '{1006, -211, -9947, -2647},
    '{9933, 596, 992, -1308}
  };
  localparam longint OffsetU16 = 480;
  localparam longint OffsetV16 = 160;
  localparam longint PixelHigh = 524287;
  localparam longint PixelLow  = -524288;

  longint              cam_q16 [3][4];
  logic [BoxW-1:0]     win_left;
  logic [BoxW-1:0]     win_top;
  logic [BoxW-1:0]     win_width;
  logic [BoxW-1:0]     win_height;
  logic [ClsW-1:0]     win_class;
  logic                win_enable;
  logic                frame_hit;
  hit_t                expected_hits [$];
  int                  fails = 0;
  int                  pending = 0;
  hit_t                want;
  hit_t                got;
  logic signed [PtW-1:0]  pt_x;
  logic signed [PtW-1:0]  pt_y;
  logic signed [PtW-1:0]  pt_z;
  logic signed [PixW-1:0] pix_u;
  logic signed [PixW-1:0] pix_v;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  // One camera matrix entry: exact sum of K times E, rounded half away from zero.
  function automatic longint camera_entry(int r, int c);
    longint acc;
    acc = 0;
    for (int k = 0; k < 3; k++) begin
      acc += IntrinsicQ16[r][k] * ExtrinsicE4[k][c];
    end
    if (acc >= 0) begin
      return (acc + 5000) / 10000;
    end
    return -((-acc + 5000) / 10000);
  endfunction

  initial begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        cam_q16[r][c] = camera_entry(r, c);
      end
    end
  end

  // Division rounded toward minus infinity for a positive divisor.
  function automatic longint floor_quot(input longint n, input longint d,
                                        output longint rem);
    longint q;
    q   = n / d;
    rem = n % d;
    if (rem < 0) begin
      q   -= 1;
      rem += d;
    end
    return q;
  endfunction

  // Span test on the exact position: both edges count as inside.
  function automatic bit in_window(longint q, longint r, logic [BoxW-1:0] lo,
                                   logic [BoxW-1:0] len);
    longint a;
    longint b;
    a = longint'(lo) * 16;
    b = (longint'(lo) + longint'(len)) * 16;
    if (q < a) begin
      return 1'b0;
    end
    return (q < b) || (q == b && r == 0);
  endfunction

  function automatic logic signed [PixW-1:0] clamp_pixel(longint v);
    if (v > PixelHigh) begin
      return PixW'(PixelHigh);
    end
    if (v < PixelLow) begin
      return PixW'(PixelLow);
    end
    return PixW'(v);
  endfunction

  // Projects one point and tells whether it lands in the box.
  function automatic bit project_point(input logic signed [PtW-1:0] x,
                                       input logic signed [PtW-1:0] y,
                                       input logic signed [PtW-1:0] z,
                                       output logic signed [PixW-1:0] u,
                                       output logic signed [PixW-1:0] v);
    longint pt [4];
    longint h [3];
    longint d;
    longint n0;
    longint n1;
    longint qu;
    longint ru;
    longint qv;
    longint rv;
    pt[0] = x;
    pt[1] = y;
    pt[2] = z;
    pt[3] = 1024;
    for (int i = 0; i < 3; i++) begin
      h[i] = 0;
      for (int j = 0; j < 4; j++) begin
        h[i] += cam_q16[i][j] * pt[j];
      end
    end
    u = '0;
    v = '0;
    if (h[2] == 0) begin
      return 1'b0;
    end
    d  = h[2];
    n0 = h[0] * 16;
    n1 = h[1] * 16;
    // A point behind the camera is divided as if it were in front.
    if (d < 0) begin
      d  = -d;
      n0 = -n0;
      n1 = -n1;
    end
    qu = floor_quot(n0, d, ru) - OffsetU16;
    qv = floor_quot(n1, d, rv) - OffsetV16;
    u  = clamp_pixel(qu);
    v  = clamp_pixel(qv);
    return in_window(qu, ru, win_left, win_width) &&
           in_window(qv, rv, win_top, win_height);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: hit mismatch: %s", $realtime, msg);
    fails++;
  endtask

  task automatic check_field(input string name, input logic signed [63:0] exp_v,
                             input logic signed [63:0] act_v);
    if (act_v !== exp_v) begin
      report_mismatch($sformatf("%s expected %0d, got %0d", name, exp_v, act_v));
    end
  endtask

  // Register mirror, prediction on accepted points, comparison on hits.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_left   = '0;
      win_top    = '0;
      win_width  = '0;
      win_height = '0;
      win_class  = ClassUnknown;
      win_enable = 1'b0;
      frame_hit  = 1'b0;
      expected_hits.delete();
      pending    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegBoxLeft:   win_left   = cfg_wdata_i[BoxW-1:0];
          RegBoxTop:    win_top    = cfg_wdata_i[BoxW-1:0];
          RegBoxWidth:  win_width  = cfg_wdata_i[BoxW-1:0];
          RegBoxHeight: win_height = cfg_wdata_i[BoxW-1:0];
          RegSignClass: win_class  = cfg_wdata_i[ClsW-1:0];
          RegBoxValid:  win_enable = cfg_wdata_i[0];
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) begin
        pt_x = in_data_i[0 +: PtW];
        pt_y = in_data_i[PtW +: PtW];
        pt_z = in_data_i[2*PtW +: PtW];
        // Only the first point of a frame inside the box is reported.
        if (win_enable && !frame_hit) begin
          if (project_point(pt_x, pt_y, pt_z, pix_u, pix_v)) begin
            want.px  = pt_x;
            want.py  = pt_y;
            want.pz  = pt_z;
            want.pu  = pix_u;
            want.pv  = pix_v;
            want.cls = win_class;
            expected_hits.push_back(want);
            frame_hit = 1'b1;
          end
        end
        if (in_last_i) begin
          frame_hit = 1'b0;
        end
      end

      if (hit_valid_i && hit_ready_i) begin
        got.px  = hit_data_i[0 +: PtW];
        got.py  = hit_data_i[PtW +: PtW];
        got.pz  = hit_data_i[2*PtW +: PtW];
        got.pu  = hit_data_i[3*PtW +: PixW];
        got.pv  = hit_data_i[3*PtW+PixW +: PixW];
        got.cls = hit_data_i[3*PtW+2*PixW +: ClsW];
        if (expected_hits.size() == 0) begin
          report_mismatch($sformatf("hit with none expected, x %0d y %0d z %0d",
                                    got.px, got.py, got.pz));
        end else begin
          want = expected_hits.pop_front();
          check_field("hit_x", want.px, got.px);
          check_field("hit_y", want.py, got.py);
          check_field("hit_z", want.pz, got.pz);
          check_field("pixel_u", want.pu, got.pu);
          check_field("pixel_v", want.pv, got.pv);
          check_field("class_out", want.cls, got.cls);
          check_field("zero fill", 0, hit_data_i[OutDataW-1:OutUsedW]);
        end
      end

      pending = expected_hits.size();
    end
  end

endmodule

// ===== sim/tb_lidar_point_bbox_projection_gate.sv =====
// Stimulus for the projection gate: register phases, directed and random
// point frames, random stalls on both streams, and the final verdict.
module tb_lidar_point_bbox_projection_gate;
  import lpbg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // The longest quiet stretch of a good run is the long receiver hold plus one
  // projection; the limit is several times that and the settling waits.
  localparam int WatchdogLimit  = 5000;
  localparam int SettleCycles   = 100;
  localparam int EndCycles      = 200;
  localparam int LongHoldCycles = 600;
  localparam int RandomPhases   = 10;
  localparam int PhaseItems     = 55;
  // Approximate image position of a point straight ahead, after the offsets.
  localparam int AimU0 = 332;
  localparam int AimV0 = 286;
  localparam int PtMax = 131071;
  localparam logic [CfgIdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 3'd7;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  int  fail_count;
  int  pending_hits;
  int  quiet_cycles = 0;
  int  sent_items = 0;
  bit  idle_on = 1'b1;
  bit  hold_req = 1'b0;
  int  box_l = 0;
  int  box_t = 0;
  int  box_w = 0;
  int  box_h = 0;

  lidar_point_bbox_projection_gate dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  lpbg_checker u_hit_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .hit_valid_i  (m_axis_tvalid),
    .hit_ready_i  (m_axis_tready),
    .hit_data_i   (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_count),
    .pending_o    (pending_hits)
  );

  // 4 ns clock.
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Watchdog: ends the run when no request moves on any channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Hit receiver: short random stalls, and one long hold on request.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LongHoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic int clamp_pt(int v);
    if (v > PtMax) begin
      return PtMax;
    end
    if (v < -PtMax) begin
      return -PtMax;
    end
    return v;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_box(input int l, input int t, input int w, input int h);
    box_l = l;
    box_t = t;
    box_w = w;
    box_h = h;
    write_reg(RegBoxLeft, CfgDataW'(l));
    write_reg(RegBoxTop, CfgDataW'(t));
    write_reg(RegBoxWidth, CfgDataW'(w));
    write_reg(RegBoxHeight, CfgDataW'(h));
  endtask

  // One point request; an optional short gap comes before it.
  task automatic send_point(input logic signed [PtW-1:0] x, input logic signed [PtW-1:0] y,
                            input logic signed [PtW-1:0] z, input logic last);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW-3*PtW){1'b0}}, z, y, x};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_items++;
  endtask

  // A point whose projection falls near or inside the current box.
  task automatic aim_point(output logic signed [PtW-1:0] x, output logic signed [PtW-1:0] y,
                           output logic signed [PtW-1:0] z);
    int depth;
    int tu;
    int tv;
    int span_u;
    int span_v;
    int yy;
    int zz;
    depth  = $urandom_range(1024, 40960);
    span_u = (box_w > 640) ? 640 : box_w;
    span_v = (box_h > 480) ? 480 : box_h;
    tu = box_l - 2 + int'($urandom_range(0, span_u + 4));
    tv = box_t - 2 + int'($urandom_range(0, span_v + 4));
    yy = clamp_pt((AimU0 - tu) * depth / 600);
    zz = clamp_pt((AimV0 - tv) * depth / 600);
    // Now and then the mirrored point behind the camera.
    if ($urandom_range(0, 7) == 0) begin
      depth = -depth;
      yy    = -yy;
      zz    = -zz;
    end
    x = PtW'(depth);
    y = PtW'(yy);
    z = PtW'(zz);
  endtask

  // A frame of aimed points mixed with raw random ones.
  task automatic send_frame(input int len, input int noise_pct);
    logic signed [PtW-1:0] x;
    logic signed [PtW-1:0] y;
    logic signed [PtW-1:0] z;
    for (int i = 0; i < len; i++) begin
      if (int'($urandom_range(0, 99)) < noise_pct) begin
        x = PtW'($urandom);
        y = PtW'($urandom);
        z = PtW'($urandom);
      end else begin
        aim_point(x, y, z);
      end
      send_point(x, y, z, i == len - 1);
    end
  endtask

  // Waits for every expected hit, then for any point still being projected.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_hits != 0) @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic pick_edge(output int v, input int hi);
    case ($urandom_range(0, 5))
      0:       v = 0;
      1:       v = 4095;
      default: v = $urandom_range(1, hi);
    endcase
  endtask

  // A random register setting, upper data bits of the narrow registers random.
  task automatic random_config();
    int l;
    int t;
    int w;
    int h;
    l = ($urandom_range(0, 5) == 0) ? 4095 : $urandom_range(0, 600);
    t = ($urandom_range(0, 5) == 0) ? 4095 : $urandom_range(0, 440);
    pick_edge(w, 300);
    pick_edge(h, 300);
    set_box(l, t, w, h);
    write_reg(RegSignClass, CfgDataW'(($urandom_range(0, 255) << ClsW) |
                                      $urandom_range(0, 15)));
    write_reg(RegBoxValid, CfgDataW'(($urandom_range(0, 2047) << 1) |
                                     ($urandom_range(0, 5) != 0)));
    if ($urandom_range(0, 2) == 0) begin
      write_reg($urandom_range(0, 1) ? RegSpareLo : RegSpareHi, CfgDataW'($urandom));
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_wdata_i   = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // No box yet: points are dropped, the last mark still clears the flag.
    send_point(40960, 0, 0, 1'b0);
    send_point(20480, 1000, -500, 1'b1);
    send_point(-131072, 131071, -131072, 1'b1);
    settle();

    // Full-size box with the class left at its reset value.
    set_box(0, 0, 4095, 4095);
    write_reg(RegBoxValid, 1);
    // Field extremes, a point behind the camera and a near-zero depth.
    send_point(131071, 0, 0, 1'b1);
    send_point(-131072, 0, 0, 1'b1);
    send_point(0, 0, 0, 1'b1);
    send_point(1024, 131071, 131071, 1'b1);
    send_point(1024, -131072, -131072, 1'b1);
    send_point(135, 1000, 0, 1'b1);
    send_point(134, 0, 0, 1'b1);
    send_point(131071, 131071, 131071, 1'b1);
    send_point(-131072, -131072, -131072, 1'b1);
    send_point(131071, -131072, 131071, 1'b1);
    // Later points of a frame that already has a hit are ignored.
    send_point(20480, 0, 0, 1'b0);
    send_point(20480, 100, 100, 1'b0);
    send_point(20480, -100, 0, 1'b1);
    send_point(20480, 0, 0, 1'b1);
    settle();
    write_reg(RegSignClass, 6);
    send_frame(3, 0);
    send_frame(2, 0);
    settle();

    // The receiver holds off while single-point hit frames keep coming,
    // so the result register fills and the input stalls.
    hold_req = 1'b1;
    repeat (12) send_frame(1, 0);
    settle();

    // Box switched off again.
    write_reg(RegBoxValid, 0);
    send_frame(4, 0);
    send_frame(3, 20);
    settle();

    // Random settings, each followed by a batch of random frames.
    for (int phase = 0; phase < RandomPhases; phase++) begin
      random_config();
      if (phase == RandomPhases - 1) begin
        idle_on = 1'b0;
      end
      sent_items = 0;
      while (sent_items < PhaseItems) begin
        send_frame($urandom_range(1, 8), 20);
      end
      settle();
    end

    repeat (EndCycles) @(posedge clk_i);
    if (fail_count == 0 && pending_hits == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
